/* rtl/core/tea_pkg.sv */
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned KEY_WORDS = 4;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    KEY_IDX_0 = 2'd0,
    KEY_IDX_1 = 2'd1,
    KEY_IDX_2 = 2'd2,
    KEY_IDX_3 = 2'd3
  } key_idx_t;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

  typedef struct packed {
    logic  kind;
    word_t a;
    word_t b;
  } blk_data_t;

  function automatic word_t mix_term(word_t half, word_t sum, word_t ka, word_t kb);
    return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
  endfunction

endpackage

/* rtl/core/tea_if.sv */
interface tea_in_if;
  logic         valid;
  logic         ready;
  logic         kind;
  logic [31:0]  left_word;
  logic [31:0]  right_word;

  modport source (output valid, output kind, output left_word, output right_word,
                  input ready);
  modport sink (input valid, input kind, input left_word, input right_word,
                output ready);
endinterface

interface tea_out_if;
  logic         valid;
  logic         ready;
  logic [31:0]  out_left_word;
  logic [31:0]  out_right_word;

  modport source (output valid, output out_left_word, output out_right_word,
                  input ready);
  modport sink (input valid, input out_left_word, input out_right_word,
                output ready);
endinterface

/* rtl/core/tea_block_cipher_engine.sv */
// TEA block cipher engine: each item is one 64-bit block (left_word, right_word)
// plus a direction bit (kind 0 encrypts, kind 1 decrypts) under the 128-bit key in
// registers 0..3. The ROUNDS rounds are unrolled into 2*ROUNDS half-round stages
// (one mix term and one 32-bit add or subtract each), so a new item is taken every
// clock unless the pipe is stalled, and its result leaves from the last stage. The whole
// pipe holds while a result waits at the output and blk_out.ready is low. Keys are
// read live by every stage: write them only while the pipe is empty.
module tea_block_cipher_engine #(
  parameter int unsigned ROUNDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  tea_in_if.sink      blk_in,
  tea_out_if.source   blk_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import tea_pkg::*;

  localparam int unsigned NSTAGE = 2 * ROUNDS;

  key_set_t  key;
  logic      en;
  logic      stage_valid [NSTAGE+1];
  blk_data_t stage_data  [NSTAGE+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (key_idx_t'(cfg_index))
        KEY_IDX_0: key[KEY_IDX_0] <= cfg_data;
        KEY_IDX_1: key[KEY_IDX_1] <= cfg_data;
        KEY_IDX_2: key[KEY_IDX_2] <= cfg_data;
        KEY_IDX_3: key[KEY_IDX_3] <= cfg_data;
        default:   key            <= key;
      endcase
    end
  end

  assign en           = ~stage_valid[NSTAGE] | blk_out.ready;
  assign blk_in.ready = en;

  assign stage_valid[0]   = blk_in.valid;
  assign stage_data[0]    = '{kind: blk_in.kind, a: blk_in.left_word, b: blk_in.right_word};

  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    localparam int unsigned RND = g / 2;
    localparam logic [31:0] SE  = 32'(64'(TEA_DELTA) * 64'(RND + 1));
    localparam logic [31:0] SD  = 32'(64'(TEA_DELTA) * 64'(ROUNDS - RND));

    tea_stage #(
      .PHASE   (1'(g % 2)),
      .SUM_ENC (SE),
      .SUM_DEC (SD)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[g]),
      .in_data   (stage_data[g]),
      .key       (key),
      .out_valid (stage_valid[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  assign blk_out.valid          = stage_valid[NSTAGE];
  assign blk_out.out_left_word  = stage_data[NSTAGE].a;
  assign blk_out.out_right_word = stage_data[NSTAGE].b;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> stage_valid[1] == $past(stage_valid[1]) && blk_out.valid)
    else $error("pipe advanced during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    blk_in.valid && blk_in.ready |=> stage_valid[1])
    else $error("accepted item missing from first stage");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !blk_out.valid && !stage_valid[1])
    else $error("pipe not empty after reset");

  a_bubble_enters: assert property (@(posedge clk) disable iff (rst)
    en && !blk_in.valid |=> !stage_valid[1])
    else $error("item invented at pipe entry");

endmodule

/* rtl/core/tea_stage.sv */
module tea_stage #(
  parameter bit          PHASE   = 1'b0,
  parameter logic [31:0] SUM_ENC = 32'h9E37_79B9,
  parameter logic [31:0] SUM_DEC = 32'hC6EF_3720
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  tea_pkg::blk_data_t in_data,
  input  tea_pkg::key_set_t  key,
  output logic               out_valid,
  output tea_pkg::blk_data_t out_data
);
  import tea_pkg::*;

  logic      update_a;
  word_t     src;
  word_t     dst;
  word_t     ka;
  word_t     kb;
  word_t     sum;
  word_t     term;
  word_t     res;
  blk_data_t data_next;

  // encrypt: a then b; decrypt: b then a
  always_comb begin
    update_a  = ~(PHASE ^ in_data.kind);
    src       = update_a ? in_data.b : in_data.a;
    dst       = update_a ? in_data.a : in_data.b;
    ka        = update_a ? key[KEY_IDX_0] : key[KEY_IDX_2];
    kb        = update_a ? key[KEY_IDX_1] : key[KEY_IDX_3];
    sum       = in_data.kind ? SUM_DEC : SUM_ENC;
    term      = mix_term(src, sum, ka, kb);
    res       = in_data.kind ? (dst - term) : (dst + term);
    data_next = in_data;
    if (update_a) begin
      data_next.a = res;
    end else begin
      data_next.b = res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= data_next;
    end
  end

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tea_pkg::*;

  localparam int unsigned ROUNDS      = 32;
  localparam int unsigned PIPE_DEPTH  = 2 * ROUNDS;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 260;

  typedef struct packed {
    word_t l;
    word_t r;
  } block_t;

  typedef struct {
    blk_data_t item;
    bit        known;
    block_t    res;
  } vector_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  tea_in_if  blk_in();
  tea_out_if blk_out();

  key_set_t    key_shadow;
  block_t      pending_blocks[$];
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;
  bit          gaps_on = 1'b1;

  // zero key throughout; first two rows are the published all-zero vector
  vector_t directed[14] = '{
    '{'{1'b0, 32'h0000_0000, 32'h0000_0000}, 1'b1, '{32'h41EA_3A0A, 32'h94BA_A940}},
    '{'{1'b1, 32'h41EA_3A0A, 32'h94BA_A940}, 1'b1, '{32'h0000_0000, 32'h0000_0000}},
    '{'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b0, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b0, 32'hFFFF_FFFF, 32'h0000_0000}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b1, 32'h0000_0000, 32'h0000_0000}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b1, 32'h0000_0000, 32'hFFFF_FFFF}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b0, 32'h8000_0000, 32'h0000_0001}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b1, 32'h0000_0001, 32'h8000_0000}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b0, 32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b1, 32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b0, 32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, '{32'h0, 32'h0}},
    '{'{1'b1, 32'h9ABC_DEF0, 32'h1234_5678}, 1'b0, '{32'h0, 32'h0}}
  };

  tea_block_cipher_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .blk_in    (blk_in),
    .blk_out   (blk_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic word_t feistel(word_t v, word_t s, word_t kx, word_t ky);
    return ((v << 4) + kx) ^ (v + s) ^ ((v >> 5) + ky);
  endfunction

  function automatic block_t tea_transform(blk_data_t d, key_set_t k);
    word_t a;
    word_t b;
    word_t s;
    a = d.a;
    b = d.b;
    if (!d.kind) begin
      s = '0;
      for (int i = 0; i < ROUNDS; i++) begin
        s += TEA_DELTA;
        a += feistel(b, s, k[0], k[1]);
        b += feistel(a, s, k[2], k[3]);
      end
    end else begin
      s = TEA_DELTA * ROUNDS;
      for (int i = 0; i < ROUNDS; i++) begin
        b -= feistel(a, s, k[2], k[3]);
        a -= feistel(b, s, k[0], k[1]);
        s -= TEA_DELTA;
      end
    end
    return '{a, b};
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 30) $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic send_block(blk_data_t d, bit known, block_t res);
    while (gaps_on && $urandom_range(99) < 20) begin
      blk_in.valid <= 1'b0;
      @(posedge clk);
    end
    blk_in.valid      <= 1'b1;
    blk_in.kind       <= d.kind;
    blk_in.left_word  <= d.a;
    blk_in.right_word <= d.b;
    do @(posedge clk); while (!blk_in.ready);
    pending_blocks.push_back(known ? res : tea_transform(d, key_shadow));
  endtask

  task automatic drain_pipe();
    blk_in.valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_keys(key_set_t k);
    for (int i = 0; i < KEY_WORDS; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= key_idx_t'(i);
      cfg_data  <= k[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    key_shadow = k;
  endtask

  always @(posedge clk) blk_out.ready <= !gaps_on || ($urandom_range(99) >= 20);

  always @(posedge clk) begin
    block_t want;
    if (!rst && blk_out.valid && blk_out.ready) begin
      if (pending_blocks.size() == 0) begin
        report_mismatch($sformatf("unexpected item %h %h",
                                  blk_out.out_left_word, blk_out.out_right_word));
      end else begin
        want = pending_blocks.pop_front();
        if (blk_out.out_left_word !== want.l)
          report_mismatch($sformatf("out_left_word %h, want %h",
                                    blk_out.out_left_word, want.l));
        if (blk_out.out_right_word !== want.r)
          report_mismatch($sformatf("out_right_word %h, want %h",
                                    blk_out.out_right_word, want.r));
      end
    end
  end

  always @(posedge clk) begin
    if ((blk_in.valid && blk_in.ready) || (blk_out.valid && blk_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    blk_data_t   d;
    block_t      c;
    key_set_t    k;
    int unsigned sent;
    bit          held;
    blk_in.valid      <= 1'b0;
    blk_in.kind       <= 1'b0;
    blk_in.left_word  <= '0;
    blk_in.right_word <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= KEY_IDX_0;
    cfg_data          <= '0;
    key_shadow = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_block(directed[i].item, directed[i].known, directed[i].res);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipe();
      case (phase)
        0: k = '1;
        1: k = {32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5};
        2: k = {32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
        default: k = {$urandom(), $urandom(), $urandom(), $urandom()};
      endcase
      load_keys(k);
      gaps_on = (phase != 3);
      sent = 0;
      held = 1'b0;
      while (sent < PHASE_ITEMS) begin
        // halfway through phase 2, hold off until everything in flight has come back
        if (phase == 2 && !held && sent >= PHASE_ITEMS / 2) begin
          drain_pipe();
          held = 1'b1;
        end
        if ($urandom_range(9) < 3) begin
          d = '{1'b0, pick_word(), pick_word()};
          c = tea_transform(d, key_shadow);
          send_block(d, 1'b0, '0);
          d = '{1'b1, c.l, c.r};
          send_block(d, 1'b0, '0);
          sent += 2;
        end else begin
          d = '{1'($urandom_range(1)), pick_word(), pick_word()};
          send_block(d, 1'b0, '0);
          sent += 1;
        end
      end
    end

    gaps_on = 1'b1;
    drain_pipe();
    repeat (PIPE_DEPTH + 16) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* tea_block_cipher_engine.f */
rtl/core/tea_pkg.sv
rtl/core/tea_if.sv
rtl/core/tea_stage.sv
rtl/core/tea_block_cipher_engine.sv
bench/tb.sv
